### hw/rtl/udp_checksum_pseudo_header_defines.svh
// Assertion macros shared by the checksum block's checker.
// No dependencies; taken in by `include where assertions are written.
`ifndef UDP_CHECKSUM_PSEUDO_HEADER_DEFINES_SVH
`define UDP_CHECKSUM_PSEUDO_HEADER_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define UDPCK_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("udp checksum assertion failed");

// Property checked on every clock edge, reset included.
`define UDPCK_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("udp checksum assertion failed during reset");

`endif

### hw/rtl/udpck_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the UDP checksum block.
// No dependencies.
package udpck_pkg;

    localparam logic [15:0] UDP_PROTOCOL = 16'd17;
    localparam logic [15:0] LEN_MAX      = 16'hFFFF;
    localparam logic [15:0] CKSUM_ALL1   = 16'hFFFF;

    // Register indexes on the configuration port.
    localparam logic REG_SRC_ADDR = 1'b0;
    localparam logic REG_DST_ADDR = 1'b1;
    localparam int   PADDR_W      = 3;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Seven 16-bit words summed before the fold.
    localparam int WIDE_SUM_W = 19;

    // Segment finished by the front: folded data sum and byte count.
    typedef struct packed {
        logic [15:0] data_sum;
        logic [15:0] length;
    } t_seg_result;

endpackage

### hw/rtl/udpck_if.sv
`timescale 1ns / 1ps
// Valid/ready channels of the UDP checksum block: segment bytes in, results out.
// No dependencies.
interface udpck_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface udpck_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] checksum;
    logic [15:0] segment_length;

    modport source (output valid, output checksum, output segment_length, input ready);
    modport sink   (input valid, input checksum, input segment_length, output ready);
endinterface

### hw/rtl/udpck_front.sv
`timescale 1ns / 1ps
// Front part: takes segment bytes, pairs them into words and keeps the running
// ones'-complement sum and byte count. Depends on udpck_pkg and udpck_if.
module udpck_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    udpck_byte_if.sink             i_seg,
    output logic                   o_push_valid,
    output udpck_pkg::t_seg_result o_push_data,
    input  logic                   i_push_ready
);

    logic [15:0] r_sum, n_sum;
    logic [15:0] r_count, n_count;
    logic [7:0]  r_held, n_held;
    logic        r_odd, n_odd;

    logic        accept;
    logic [15:0] word;
    logic [16:0] add_wide;
    logic [15:0] sum_added;
    logic [15:0] count_inc;

    // A byte is only taken when the queue has room, whether or not it is a last byte.
    assign i_seg.ready  = i_push_ready;
    assign accept       = i_seg.valid && i_push_ready;
    assign o_push_valid = i_seg.valid && i_seg.last;

    assign word      = r_odd ? {r_held, i_seg.data_byte} : {i_seg.data_byte, 8'h00};
    assign add_wide  = {1'b0, r_sum} + {1'b0, word};
    assign sum_added = add_wide[15:0] + {15'd0, add_wide[16]};
    assign count_inc = (r_count == udpck_pkg::LEN_MAX) ? r_count : r_count + 16'd1;

    assign o_push_data.data_sum = (r_odd || i_seg.last) ? sum_added : r_sum;
    assign o_push_data.length   = count_inc;

    always_comb begin
        n_sum   = r_sum;
        n_count = r_count;
        n_held  = r_held;
        n_odd   = r_odd;
        if (accept) begin
            if (i_seg.last) begin
                n_sum   = 16'd0;
                n_count = 16'd0;
                n_held  = 8'd0;
                n_odd   = 1'b0;
            end else if (r_odd) begin
                n_sum   = sum_added;
                n_count = count_inc;
                n_odd   = 1'b0;
            end else begin
                n_count = count_inc;
                n_held  = i_seg.data_byte;
                n_odd   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= 16'd0;
            r_count <= 16'd0;
            r_held  <= 8'd0;
            r_odd   <= 1'b0;
        end else begin
            r_sum   <= n_sum;
            r_count <= n_count;
            r_held  <= n_held;
            r_odd   <= n_odd;
        end
    end

endmodule

### hw/rtl/udpck_queue.sv
`timescale 1ns / 1ps
// Short queue of finished segment sums between front and back.
// Depends on udpck_pkg.
module udpck_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push_valid,
    input  udpck_pkg::t_seg_result i_push_data,
    output logic                   o_push_ready,
    output logic                   o_pop_valid,
    output udpck_pkg::t_seg_result o_pop_data,
    input  logic                   i_pop_ready
);

    udpck_pkg::t_seg_result r_entry [udpck_pkg::QUEUE_DEPTH];
    logic [udpck_pkg::QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [udpck_pkg::QCNT_W-1:0] r_count;
    logic push, pop;

    assign o_push_ready = (r_count != udpck_pkg::QCNT_W'(udpck_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_entry[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_entry[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == udpck_pkg::QPTR_W'(udpck_pkg::QUEUE_DEPTH - 1))
                          ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == udpck_pkg::QPTR_W'(udpck_pkg::QUEUE_DEPTH - 1))
                          ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### hw/rtl/udpck_back.sv
`timescale 1ns / 1ps
// Back part: adds the IPv4 pseudo-header to a segment sum, folds, complements
// and holds the result for transfer. Depends on udpck_pkg and udpck_if.
module udpck_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [31:0]            i_src_addr,
    input  logic [31:0]            i_dst_addr,
    input  logic                   i_pop_valid,
    input  udpck_pkg::t_seg_result i_pop_data,
    output logic                   o_pop_ready,
    udpck_result_if.source         o_res
);

    localparam int SW = udpck_pkg::WIDE_SUM_W;

    logic          r_a_valid;
    logic [SW-1:0] r_a_sum;
    logic [15:0]   r_a_len;
    logic          r_o_valid;
    logic [15:0]   r_o_cksum;
    logic [15:0]   r_o_len;

    logic          a_load, o_load, o_free;
    logic [SW-1:0] wide_sum;
    logic [16:0]   fold1;
    logic [15:0]   fold2;
    logic [15:0]   cksum;

    assign o_free      = !r_o_valid || o_res.ready;
    assign o_load      = r_a_valid && o_free;
    assign o_pop_ready = !r_a_valid || o_free;
    assign a_load      = i_pop_valid && o_pop_ready;

    assign wide_sum = SW'(i_pop_data.data_sum) + SW'(i_src_addr[31:16])
                    + SW'(i_src_addr[15:0]) + SW'(i_dst_addr[31:16])
                    + SW'(i_dst_addr[15:0]) + SW'(udpck_pkg::UDP_PROTOCOL)
                    + SW'(i_pop_data.length);

    // Two end-around folds bring the 19-bit total back to 16 bits.
    assign fold1 = {1'b0, r_a_sum[15:0]} + 17'(r_a_sum[SW-1:16]);
    assign fold2 = fold1[15:0] + {15'd0, fold1[16]};
    // A zero checksum is sent as all ones.
    assign cksum = (fold2 == udpck_pkg::CKSUM_ALL1) ? udpck_pkg::CKSUM_ALL1 : ~fold2;

    always_ff @(posedge i_clk) begin
        if (a_load) begin
            r_a_sum <= wide_sum;
            r_a_len <= i_pop_data.length;
        end
        if (o_load) begin
            r_o_cksum <= cksum;
            r_o_len   <= r_a_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_pop_ready) begin
                r_a_valid <= i_pop_valid;
            end
            if (o_free) begin
                r_o_valid <= r_a_valid;
            end
        end
    end

    assign o_res.valid          = r_o_valid;
    assign o_res.checksum       = r_o_cksum;
    assign o_res.segment_length = r_o_len;

endmodule

### hw/rtl/udp_checksum_pseudo_header.sv
`timescale 1ns / 1ps
// Top level of the UDP checksum block with its APB register port.
// Depends on udpck_pkg, udpck_if, udpck_front, udpck_queue and udpck_back.

// Takes UDP segment bytes (header with the checksum field zero, then payload,
// last byte marked) and returns one result per segment: the checksum over the
// IPv4 pseudo-header and the segment, and the byte count, saturating at
// 65535. Bytes are taken at one per clock while the queue has room. A result
// passes from the queue entry written when the last byte is taken, through
// the pseudo-header add into the back's first register, to the fold into the
// output register; result backpressure can hold it in either. A new segment
// may start in the cycle after a last byte. A two-entry queue lets the byte
// side keep running while results wait. Address registers: source at byte
// address 0, destination at 4; they are read when a segment leaves the queue,
// so write them only while no segment or result is in flight.
module udp_checksum_pseudo_header (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    udpck_byte_if.sink                       i_seg,
    udpck_result_if.source                   o_res,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [udpck_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    logic [31:0] r_src_addr;
    logic [31:0] r_dst_addr;
    logic        cfg_write;

    logic                   push_valid, push_ready;
    udpck_pkg::t_seg_result push_data;
    logic                   pop_valid, pop_ready;
    udpck_pkg::t_seg_result pop_data;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_addr <= 32'd0;
            r_dst_addr <= 32'd0;
        end else if (cfg_write) begin
            unique case (paddr[2])
                udpck_pkg::REG_SRC_ADDR: r_src_addr <= pwdata;
                udpck_pkg::REG_DST_ADDR: r_dst_addr <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            udpck_pkg::REG_SRC_ADDR: prdata = r_src_addr;
            udpck_pkg::REG_DST_ADDR: prdata = r_dst_addr;
            default:                 prdata = 32'd0;
        endcase
    end

    udpck_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seg        (i_seg),
        .o_push_valid (push_valid),
        .o_push_data  (push_data),
        .i_push_ready (push_ready)
    );

    udpck_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_data  (push_data),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_data   (pop_data),
        .i_pop_ready  (pop_ready)
    );

    udpck_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_src_addr  (r_src_addr),
        .i_dst_addr  (r_dst_addr),
        .i_pop_valid (pop_valid),
        .i_pop_data  (pop_data),
        .o_pop_ready (pop_ready),
        .o_res       (o_res)
    );

endmodule

### hw/rtl/udpck_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for the UDP checksum block, bound to its top level.
// Depends on udp_checksum_pseudo_header_defines.svh.
`include "udp_checksum_pseudo_header_defines.svh"

module udpck_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic [15:0] i_res_checksum,
    input logic [15:0] i_res_length
);

    // Nothing comes out in the cycle after reset.
    `UDPCK_ASSERT_ALWAYS(a_idle_after_reset, i_clk, !i_rst_n |=> !i_res_valid)

    // A zero checksum is never sent.
    `UDPCK_ASSERT(a_cksum_nonzero, i_clk, i_rst_n, i_res_valid |-> i_res_checksum != 16'd0)

    // Every segment has at least its last byte.
    `UDPCK_ASSERT(a_len_nonzero, i_clk, i_rst_n, i_res_valid |-> i_res_length != 16'd0)

    // A stalled result holds.
    `UDPCK_ASSERT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_checksum) && $stable(i_res_length))

endmodule

bind udp_checksum_pseudo_header udpck_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_res_checksum (o_res.checksum),
    .i_res_length   (o_res.segment_length)
);

### verif/tb_udp_checksum_pseudo_header.sv
`timescale 1ns / 1ps
// Self-checking testbench for udp_checksum_pseudo_header: streams UDP segments byte by
// byte, predicts checksum and length per segment, and compares each result transfer.
// Depends on udpck_pkg, udpck_if and the block's RTL.
module tb_udp_checksum_pseudo_header;

    localparam int  CLK_HALF     = 6;
    localparam int  DRAIN_CYCLES = 8;
    localparam int  END_WAIT_MAX = 4000;
    localparam int  RANDOM_BYTES = 1500;
    localparam logic [udpck_pkg::PADDR_W-1:0] ADDR_SRC = {udpck_pkg::REG_SRC_ADDR, 2'b00};
    localparam logic [udpck_pkg::PADDR_W-1:0] ADDR_DST = {udpck_pkg::REG_DST_ADDR, 2'b00};

    typedef struct packed {
        logic [15:0] checksum;
        logic [15:0] seg_len;
    } t_seg_expect;

    typedef logic [7:0] t_byte_q[$];

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [udpck_pkg::PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    udpck_byte_if   seg_if ();
    udpck_result_if res_if ();

    udp_checksum_pseudo_header u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (seg_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state: address shadows and the open segment's running sum.
    logic [31:0] src_addr_shadow;
    logic [31:0] dst_addr_shadow;
    logic [15:0] seg_sum;
    logic [15:0] seg_count;
    logic [7:0]  held_byte;
    logic        odd_half;

    t_seg_expect expected_results[$];
    int          err_count;
    int          ready_hold;
    bit          calm;

    always #(CLK_HALF) i_clk = ~i_clk;

    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    // Pseudo-header contribution for the current addresses and a given length.
    function automatic logic [15:0] pseudo_sum(input logic [15:0] len);
        logic [15:0] s;
        s = ones_add(16'd0, src_addr_shadow[31:16]);
        s = ones_add(s, src_addr_shadow[15:0]);
        s = ones_add(s, dst_addr_shadow[31:16]);
        s = ones_add(s, dst_addr_shadow[15:0]);
        s = ones_add(s, udpck_pkg::UDP_PROTOCOL);
        return ones_add(s, len);
    endfunction

    // Mostly short gaps, a few long ones; none while calm.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR @%0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        err_count++;
    endtask

    task automatic predict_byte(input logic [7:0] data_byte, input logic is_last);
        logic [15:0] s;
        t_seg_expect res;
        if (seg_count != udpck_pkg::LEN_MAX)
            seg_count++;
        if (odd_half) begin
            seg_sum   = ones_add(seg_sum, {held_byte, data_byte});
            odd_half  = 1'b0;
            held_byte = 8'd0;
        end else if (is_last) begin
            // lone final byte is the high half of a zero-padded word
            seg_sum = ones_add(seg_sum, {data_byte, 8'h00});
        end else begin
            held_byte = data_byte;
            odd_half  = 1'b1;
        end
        if (is_last) begin
            s = seg_sum;
            s = ones_add(s, src_addr_shadow[31:16]);
            s = ones_add(s, src_addr_shadow[15:0]);
            s = ones_add(s, dst_addr_shadow[31:16]);
            s = ones_add(s, dst_addr_shadow[15:0]);
            s = ones_add(s, udpck_pkg::UDP_PROTOCOL);
            s = ones_add(s, seg_count);
            res.checksum = ~s;
            if (res.checksum == 16'h0000)
                res.checksum = udpck_pkg::CKSUM_ALL1;
            res.seg_len = seg_count;
            expected_results.push_back(res);
            seg_sum   = 16'd0;
            seg_count = 16'd0;
            held_byte = 8'd0;
            odd_half  = 1'b0;
        end
    endtask

    task automatic send_byte(input logic [7:0] data_byte, input logic is_last);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            seg_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        seg_if.valid     <= 1'b1;
        seg_if.data_byte <= data_byte;
        seg_if.last      <= is_last;
        do @(posedge i_clk); while (!seg_if.ready);
        predict_byte(data_byte, is_last);
    endtask

    task automatic send_segment(input t_byte_q bytes);
        foreach (bytes[i])
            send_byte(bytes[i], i == bytes.size() - 1);
    endtask

    task automatic end_stream();
        @(negedge i_clk);
        seg_if.valid <= 1'b0;
        seg_if.last  <= 1'b0;
    endtask

    // Block between segments with every expected transfer received.
    task automatic wait_drained();
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [udpck_pkg::PADDR_W-1:0] addr,
                             input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_SRC)
            src_addr_shadow = value;
        else if (addr == ADDR_DST)
            dst_addr_shadow = value;
    endtask

    task automatic apb_read_check(input logic [udpck_pkg::PADDR_W-1:0] addr,
                                  input logic [31:0] want);
        logic [31:0] got;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want)
            report_mismatch($sformatf("register read at 0x%0h", addr), got, want);
    endtask

    task automatic set_addresses(input logic [31:0] src, input logic [31:0] dst);
        // drop valid first so the last byte is not taken again while draining
        end_stream();
        wait_drained();
        apb_write(ADDR_SRC, src);
        apb_write(ADDR_DST, dst);
        apb_read_check(ADDR_SRC, src);
        apb_read_check(ADDR_DST, dst);
    endtask

    // UDP header with the length filled in, then payload; optionally a bad header.
    function automatic t_byte_q build_datagram(input int payload_len, input bit broken);
        t_byte_q q;
        logic [15:0] len_field;
        logic [15:0] ck_field;
        len_field = 16'(8 + payload_len);
        ck_field  = 16'h0000;
        if (broken) begin
            len_field = 16'($urandom);
            ck_field  = 16'($urandom);
        end
        q.push_back(8'($urandom));
        q.push_back(8'($urandom));
        q.push_back(8'($urandom));
        q.push_back(8'($urandom));
        q.push_back(len_field[15:8]);
        q.push_back(len_field[7:0]);
        q.push_back(ck_field[15:8]);
        q.push_back(ck_field[7:0]);
        repeat (payload_len) q.push_back(8'($urandom));
        return q;
    endfunction

    task automatic test_register_access();
        apb_read_check(ADDR_SRC, 32'h0);
        apb_read_check(ADDR_DST, 32'h0);
        set_addresses(32'hC0A8_0001, 32'h0A00_0002);
    endtask

    task automatic test_short_segments();
        // single byte segments at both extremes of the data field
        send_segment('{8'h00});
        send_segment('{8'hFF});
        send_segment('{8'h12, 8'h34, 8'h56});
        set_addresses(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_segment('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        send_segment('{8'h80});
        set_addresses(32'h0000_0000, 32'h0000_0000);
        send_segment('{8'h00, 8'h00, 8'h00, 8'h08, 8'h00, 8'h08, 8'h00, 8'h00});
        end_stream();
    endtask

    // Pick the last word so the folded total is all ones and the checksum is zero.
    task automatic test_zero_checksum();
        logic [15:0] word;
        set_addresses(32'h0A0B_0C0D, 32'hF0E0_D0C0);
        word = 16'hFFFF - pseudo_sum(16'd2);
        send_segment('{word[15:8], word[7:0]});
        set_addresses(32'h0000_0000, 32'h0000_0000);
        word = 16'hFFFF - pseudo_sum(16'd2);
        send_segment('{word[15:8], word[7:0]});
        end_stream();
    endtask

    task automatic test_random_traffic();
        int sent;
        int seg_no;
        int r;
        t_byte_q seg;
        sent   = 0;
        seg_no = 0;
        while (sent < RANDOM_BYTES) begin
            if (seg_no % 12 == 0) begin
                end_stream();
                r = $urandom_range(0, 5);
                if (r == 0)
                    set_addresses(32'hFFFF_FFFF, 32'hFFFF_FFFF);
                else if (r == 1)
                    set_addresses(32'h0000_0000, 32'hFFFF_FFFF);
                else
                    set_addresses(32'($urandom), 32'($urandom));
            end
            calm = ($urandom_range(0, 9) == 0);
            r = $urandom_range(0, 99);
            seg.delete();
            if (r < 20) begin
                // noise: arbitrary bytes, often shorter than a header
                repeat ($urandom_range(1, 12)) seg.push_back(8'($urandom));
            end else begin
                seg = build_datagram($urandom_range(0, 48), r < 25);
            end
            send_segment(seg);
            sent += seg.size();
            seg_no++;
        end
        calm = 1'b0;
        end_stream();
    endtask

    // Result side: random backpressure.
    always @(negedge i_clk) begin
        if (!i_rst_n || ready_hold == 0) begin
            res_if.ready <= 1'b1;
            ready_hold = pick_gap();
        end else begin
            res_if.ready <= 1'b0;
            ready_hold--;
        end
    end

    always @(posedge i_clk) begin
        t_seg_expect want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result, checksum", res_if.checksum, 32'h0);
            end else begin
                want = expected_results.pop_front();
                if (res_if.checksum !== want.checksum)
                    report_mismatch("checksum", res_if.checksum, want.checksum);
                if (res_if.segment_length !== want.seg_len)
                    report_mismatch("segment_length", res_if.segment_length, want.seg_len);
            end
        end
    end

    initial begin
        #(12ns * 900_000);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int waited;
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        seg_if.valid     = 1'b0;
        seg_if.data_byte = 8'h00;
        seg_if.last      = 1'b0;
        res_if.ready     = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = 32'h0;
        src_addr_shadow  = 32'h0;
        dst_addr_shadow  = 32'h0;
        seg_sum          = 16'd0;
        seg_count        = 16'd0;
        held_byte        = 8'd0;
        odd_half         = 1'b0;
        err_count        = 0;
        ready_hold       = 0;
        calm             = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_register_access();
        test_short_segments();
        test_zero_checksum();
        test_random_traffic();

        waited = 0;
        while (expected_results.size() != 0 && waited < END_WAIT_MAX) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_mismatch("results never transferred", expected_results.size(), 32'h0);
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/udpck_pkg.sv
hw/rtl/udpck_if.sv
hw/rtl/udpck_front.sv
hw/rtl/udpck_queue.sv
hw/rtl/udpck_back.sv
hw/rtl/udp_checksum_pseudo_header.sv
hw/rtl/udpck_checker.sv
verif/tb_udp_checksum_pseudo_header.sv
